FILE: rtl/slq_pkg.sv
package slq_pkg;

	localparam int DATA_W    = 32;
	localparam int DEPTH_DEF = 16;
	localparam int COUNT_W   = 5;

	// item actions
	typedef enum logic [1:0] {
		ACT_APPEND  = 2'd0,
		ACT_SORTED  = 2'd1,
		ACT_DELVAL  = 2'd2,
		ACT_DELHEAD = 2'd3
	} action_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_MISSING = 2'd3
	} status_t;

	// token traveling along the cell row
	typedef struct packed {
		logic                     tok;
		logic                     shift;
		logic signed [DATA_W-1:0] carry;
	} link_t;

	// operation broadcast to every cell
	typedef struct packed {
		logic ins;
		logic sorted;
	} op_t;

	// per-cell completion report
	typedef struct packed {
		logic done;
		logic found;
	} stat_t;

endpackage

FILE: rtl/slq_if.sv
interface slq_req_if;
	logic                             valid;
	logic                             ready;
	logic [1:0]                       action;
	logic signed [slq_pkg::DATA_W-1:0] value;

	modport source (output valid, output action, output value, input ready);
	modport sink (input valid, input action, input value, output ready);
endinterface

interface slq_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        status;
	logic [slq_pkg::COUNT_W-1:0]       count;
	logic                              head_valid;
	logic signed [slq_pkg::DATA_W-1:0] head_value;

	modport source (output valid, output status, output count, output head_valid,
		output head_value, input ready);
	modport sink (input valid, input status, input count, input head_valid,
		input head_value, output ready);
endinterface

FILE: rtl/sorted_list_queue.sv
// a rejected item (full or empty) goes straight to the result word; any other item
// sends a token along the cell row, and a delete on a full list has its token leave
// the row at the last cell
// throughput: one item at a time, set by the token walk along the cell row;
// a result word waiting on the output does not block the next accept
// reset: arst_n clears the entry count, the token and the control state, not the entries
module sorted_list_queue #(
	parameter int DEPTH = slq_pkg::DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	slq_req_if.sink    req,
	slq_rsp_if.source  rsp
);

	localparam int CntW = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SWEEP  = 3'b010,
		S_REPORT = 3'b100
	} state_t;

	state_t                            state_q;
	logic [CntW-1:0]                   fill_q;
	slq_pkg::op_t                      op_q;
	slq_pkg::status_t                  pend_q;
	logic                              rsp_valid_q;
	slq_pkg::status_t                  rsp_status_q;
	logic [slq_pkg::COUNT_W-1:0]       rsp_count_q;
	logic                              rsp_head_valid_q;
	logic signed [slq_pkg::DATA_W-1:0] rsp_head_value_q;

	slq_pkg::link_t                    links [DEPTH+1];
	slq_pkg::stat_t                    cell_stat [DEPTH];
	logic signed [slq_pkg::DATA_W-1:0] cell_val [DEPTH];

	logic                              accept;
	logic                              is_ins;
	logic                              full;
	logic                              empty;
	logic                              sweep_done;
	logic                              sweep_found;
	logic                              load_rsp;
	logic [CntW+slq_pkg::COUNT_W-1:0]  fill_ext;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign is_ins    = (req.action == slq_pkg::ACT_APPEND) || (req.action == slq_pkg::ACT_SORTED);
	assign full      = (fill_q == CntW'(DEPTH));
	assign empty     = (fill_q == '0);
	assign load_rsp  = (state_q == S_REPORT) && (!rsp_valid_q || rsp.ready);

	// token injection into the first cell
	assign links[0].tok   = accept && (is_ins ? !full : !empty);
	assign links[0].shift = (req.action == slq_pkg::ACT_DELHEAD);
	assign links[0].carry = req.value;

	// row of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                              occ;
		logic signed [slq_pkg::DATA_W-1:0] right_val;

		assign occ = (fill_q > CntW'(i));
		if (i == DEPTH - 1) begin : g_last
			assign right_val = '0;
		end else begin : g_mid
			assign right_val = cell_val[i+1];
		end

		slq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.link_i    (links[i]),
			.link_o    (links[i+1]),
			.op        (op_q),
			.occ       (occ),
			.right_val (right_val),
			.val_o     (cell_val[i]),
			.stat_o    (cell_stat[i])
		);
	end

	// collect completion from the row, or the token falling off the end
	always_comb begin
		sweep_done  = links[DEPTH].tok;
		sweep_found = links[DEPTH].tok && links[DEPTH].shift;
		for (int i = 0; i < DEPTH; i++) begin
			sweep_done  = sweep_done | cell_stat[i].done;
			sweep_found = sweep_found | (cell_stat[i].done & cell_stat[i].found);
		end
	end

	// control sequencer and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if ((is_ins && full) || (!is_ins && empty)) begin
							state_q <= S_REPORT;
						end else begin
							state_q <= S_SWEEP;
						end
					end
				end
				S_SWEEP: begin
					if (sweep_done) begin
						state_q <= S_REPORT;
						if (sweep_found) begin
							fill_q <= op_q.ins ? fill_q + CntW'(1) : fill_q - CntW'(1);
						end
					end
				end
				S_REPORT: begin
					if (load_rsp) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// operation and pending status
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q.ins    <= is_ins;
			op_q.sorted <= (req.action == slq_pkg::ACT_SORTED);
			if (is_ins && full) begin
				pend_q <= slq_pkg::ST_FULL;
			end else if (!is_ins && empty) begin
				pend_q <= slq_pkg::ST_EMPTY;
			end else begin
				pend_q <= slq_pkg::ST_OK;
			end
		end else if ((state_q == S_SWEEP) && sweep_done && !op_q.ins && !sweep_found) begin
			pend_q <= slq_pkg::ST_MISSING;
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign fill_ext = (CntW + slq_pkg::COUNT_W)'(fill_q);

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_status_q     <= pend_q;
			rsp_count_q      <= fill_ext[slq_pkg::COUNT_W-1:0];
			rsp_head_valid_q <= !empty;
			rsp_head_value_q <= empty ? '0 : cell_val[0];
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.count      = rsp_count_q;
	assign rsp.head_valid = rsp_head_valid_q;
	assign rsp.head_value = rsp_head_value_q;

endmodule

FILE: rtl/slq_cell.sv
module slq_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  slq_pkg::link_t                    link_i,
	output slq_pkg::link_t                    link_o,
	input  slq_pkg::op_t                      op,
	input  logic                              occ,
	input  logic signed [slq_pkg::DATA_W-1:0] right_val,
	output logic signed [slq_pkg::DATA_W-1:0] val_o,
	output slq_pkg::stat_t                    stat_o
);

	logic                              tok_q;
	logic                              shift_q;
	logic signed [slq_pkg::DATA_W-1:0] carry_q;
	logic signed [slq_pkg::DATA_W-1:0] val_q;
	logic signed [slq_pkg::DATA_W-1:0] val_d;
	logic                              done;

	// token presence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= link_i.tok;
		end
	end

	// carried word and entry value
	always_ff @(posedge clk) begin
		if (link_i.tok) begin
			shift_q <= link_i.shift;
			carry_q <= link_i.carry;
		end
		val_q <= val_d;
	end

	// local step while the token sits here
	always_comb begin
		val_d        = val_q;
		done         = 1'b0;
		stat_o       = '0;
		link_o.shift = shift_q;
		link_o.carry = carry_q;
		if (tok_q) begin
			if (op.ins) begin
				if (!occ) begin
					// first free slot takes whatever is carried
					val_d        = carry_q;
					done         = 1'b1;
					stat_o.found = 1'b1;
				end else if (shift_q || (op.sorted && (val_q > carry_q))) begin
					val_d        = carry_q;
					link_o.carry = val_q;
					link_o.shift = 1'b1;
				end
			end else begin
				if (!occ) begin
					done         = 1'b1;
					stat_o.found = shift_q;
				end else if (shift_q || (val_q == carry_q)) begin
					// close the gap by pulling from the right
					val_d        = right_val;
					link_o.shift = 1'b1;
				end
			end
		end
		stat_o.done = done;
		link_o.tok  = tok_q && !done;
	end

	assign val_o = val_q;

endmodule

FILE: dv/tb_sorted_list_queue.sv
module tb_sorted_list_queue;

	localparam int LIST_DEPTH  = slq_pkg::DEPTH_DEF;
	localparam int DATA_W      = slq_pkg::DATA_W;
	localparam int CNT_W       = slq_pkg::COUNT_W;
	localparam int RAND_WORDS  = 1000;
	localparam int CALM_WORDS  = 150;
	localparam int CYCLE_LIMIT = 400000;

	// one command word waiting to be sent
	typedef struct {
		slq_pkg::action_t         act;
		logic signed [DATA_W-1:0] val;
		bit                       drain;
		bit                       calm;
	} list_cmd_t;

	// what a result word should look like
	typedef struct {
		slq_pkg::status_t         status;
		logic [CNT_W-1:0]         count;
		logic                     head_valid;
		logic signed [DATA_W-1:0] head_value;
	} list_view_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	slq_req_if req_ch ();
	slq_rsp_if rsp_ch ();

	sorted_list_queue #(.DEPTH(LIST_DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	list_cmd_t                cmd_fifo[$];
	list_view_t               view_fifo[$];
	logic signed [DATA_W-1:0] shadow_list[$];
	logic signed [DATA_W-1:0] value_pool[16];

	int  words_total = 0;
	int  words_in = 0;
	int  words_out = 0;
	int  mismatches = 0;
	int  cycles = 0;
	int  src_gap = 0;
	int  sink_gap = 0;
	int  src_idle_pct = 0;
	int  sink_idle_pct = 0;
	bit  calm_phase = 1'b0;

	always #4 clk = ~clk;

	// shadow list update, returns the view after one command word
	function automatic list_view_t apply_to_list(slq_pkg::action_t act,
			logic signed [DATA_W-1:0] val);
		list_view_t view;
		int         pos;
		view.status = slq_pkg::ST_OK;
		if (act == slq_pkg::ACT_APPEND || act == slq_pkg::ACT_SORTED) begin
			if (shadow_list.size() >= LIST_DEPTH) begin
				view.status = slq_pkg::ST_FULL;
			end else begin
				pos = shadow_list.size();
				if (act == slq_pkg::ACT_SORTED) begin
					// first entry strictly greater, so equal values keep arrival order
					for (pos = 0; pos < shadow_list.size(); pos++)
						if (shadow_list[pos] > val)
							break;
				end
				shadow_list.insert(pos, val);
			end
		end else if (shadow_list.size() == 0) begin
			view.status = slq_pkg::ST_EMPTY;
		end else if (act == slq_pkg::ACT_DELHEAD) begin
			shadow_list.delete(0);
		end else begin
			for (pos = 0; pos < shadow_list.size(); pos++)
				if (shadow_list[pos] == val)
					break;
			if (pos >= shadow_list.size())
				view.status = slq_pkg::ST_MISSING;
			else
				shadow_list.delete(pos);
		end
		view.count      = CNT_W'(shadow_list.size());
		view.head_valid = shadow_list.size() > 0;
		view.head_value = shadow_list.size() > 0 ? shadow_list[0] : '0;
		return view;
	endfunction

	function automatic int pick_idle_pct();
		case ($urandom_range(2))
			0: return 0;
			1: return 8;
			default: return 30;
		endcase
	endfunction

	task automatic queue_cmd(slq_pkg::action_t act, logic signed [DATA_W-1:0] val,
			bit drain, bit calm);
		list_cmd_t cmd;
		cmd.act   = act;
		cmd.val   = val;
		cmd.drain = drain;
		cmd.calm  = calm;
		cmd_fifo.push_back(cmd);
		words_total++;
	endtask

	// biased toward growing or shrinking so the list swings between empty and full
	function automatic slq_pkg::action_t pick_action(bit grow);
		int r;
		r = $urandom_range(99);
		if (grow ? (r < 75) : (r < 25))
			return ($urandom_range(99) < 40) ? slq_pkg::ACT_APPEND : slq_pkg::ACT_SORTED;
		return ($urandom_range(99) < 60) ? slq_pkg::ACT_DELVAL : slq_pkg::ACT_DELHEAD;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid  <= 1'b0;
			req_ch.action <= '0;
			req_ch.value  <= '0;
			src_gap = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				view_fifo.push_back(apply_to_list(slq_pkg::action_t'(req_ch.action),
					req_ch.value));
				words_in++;
				if (words_in % 64 == 0)
					src_idle_pct = pick_idle_pct();
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (src_gap != 0) begin
					src_gap--;
					req_ch.valid <= 1'b0;
				end else if (cmd_fifo.size() == 0) begin
					req_ch.valid <= 1'b0;
				end else if (cmd_fifo[0].drain && view_fifo.size() != 0) begin
					// hold off until every outstanding result word is back
					req_ch.valid <= 1'b0;
				end else if (!cmd_fifo[0].calm && $urandom_range(99) < src_idle_pct) begin
					src_gap = $urandom_range(17);
					req_ch.valid <= 1'b0;
				end else begin
					calm_phase = cmd_fifo[0].calm;
					req_ch.valid  <= 1'b1;
					req_ch.action <= cmd_fifo[0].act;
					req_ch.value  <= cmd_fifo[0].val;
					void'(cmd_fifo.pop_front());
				end
			end
		end
	end

	// result monitor and ready generation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			sink_gap = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				words_out++;
				if (view_fifo.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result word %0d arrived with nothing expected", words_out);
				end else begin
					list_view_t want;
					want = view_fifo.pop_front();
					if (rsp_ch.status !== want.status || rsp_ch.count !== want.count ||
							rsp_ch.head_valid !== want.head_valid ||
							rsp_ch.head_value !== want.head_value) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("result word %0d: expected st=%0d cnt=%0d hv=%0b head=%0d",
								words_out, want.status, want.count, want.head_valid,
								want.head_value);
							$display("  got st=%0d cnt=%0d hv=%0b head=%0d",
								rsp_ch.status, rsp_ch.count, rsp_ch.head_valid,
								rsp_ch.head_value);
						end
					end
				end
				if (words_out % 64 == 0)
					sink_idle_pct = pick_idle_pct();
			end
			if (sink_gap != 0) begin
				sink_gap--;
				rsp_ch.ready <= 1'b0;
			end else if (!calm_phase && $urandom_range(99) < sink_idle_pct) begin
				sink_gap = $urandom_range(17);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		bit                       grow;
		slq_pkg::action_t         act;
		logic signed [DATA_W-1:0] val;

		// pool of values that repeat, so deletes hit and sorted inserts meet equals
		value_pool[0] = 32'h8000_0000;
		value_pool[1] = 32'h7fff_ffff;
		value_pool[2] = '0;
		value_pool[3] = '1;
		for (int i = 4; i < 16; i++)
			value_pool[i] = (i < 10) ? $urandom_range(20) - 10 : $urandom;

		// deletes on an empty list
		queue_cmd(slq_pkg::ACT_DELHEAD, '0, 0, 0);
		queue_cmd(slq_pkg::ACT_DELVAL, 32'h1234_5678, 0, 0);
		// fill to capacity with extremes, equal values and out-of-order appends
		queue_cmd(slq_pkg::ACT_SORTED, 32'h0000_0000, 0, 0);
		queue_cmd(slq_pkg::ACT_SORTED, 32'h7fff_ffff, 0, 0);
		queue_cmd(slq_pkg::ACT_SORTED, 32'h8000_0000, 0, 0);
		queue_cmd(slq_pkg::ACT_SORTED, 32'h0000_0000, 0, 0);
		queue_cmd(slq_pkg::ACT_APPEND, 32'hffff_ffff, 0, 0);
		queue_cmd(slq_pkg::ACT_SORTED, 32'hffff_ffff, 0, 0);
		queue_cmd(slq_pkg::ACT_APPEND, 32'h8000_0000, 0, 0);
		queue_cmd(slq_pkg::ACT_SORTED, 32'd5, 0, 0);
		queue_cmd(slq_pkg::ACT_SORTED, 32'h7fff_ffff, 0, 0);
		queue_cmd(slq_pkg::ACT_APPEND, 32'haaaa_aaaa, 0, 0);
		queue_cmd(slq_pkg::ACT_SORTED, 32'h5555_5555, 0, 0);
		queue_cmd(slq_pkg::ACT_APPEND, 32'd1, 0, 0);
		queue_cmd(slq_pkg::ACT_SORTED, 32'hffff_fffe, 0, 0);
		queue_cmd(slq_pkg::ACT_SORTED, 32'd3, 0, 0);
		queue_cmd(slq_pkg::ACT_APPEND, 32'd7, 0, 0);
		queue_cmd(slq_pkg::ACT_SORTED, 32'd2, 0, 0);
		// full list rejects both kinds of insert
		queue_cmd(slq_pkg::ACT_APPEND, 32'd9, 1, 0);
		queue_cmd(slq_pkg::ACT_SORTED, 32'd4, 0, 0);
		// value not present, then deletes of duplicate, extreme, head and tail
		queue_cmd(slq_pkg::ACT_DELVAL, 32'd123456, 0, 0);
		queue_cmd(slq_pkg::ACT_DELVAL, 32'h0000_0000, 0, 0);
		queue_cmd(slq_pkg::ACT_DELVAL, 32'h8000_0000, 0, 0);
		queue_cmd(slq_pkg::ACT_DELHEAD, '0, 0, 0);
		queue_cmd(slq_pkg::ACT_DELVAL, 32'd7, 0, 0);

		// random part in grow and shrink segments
		grow = 1'b1;
		for (int n = 0; n < RAND_WORDS; n++) begin
			if (n % 24 == 0)
				grow = 1'($urandom_range(1));
			act = pick_action(grow);
			if ($urandom_range(99) < ((act == slq_pkg::ACT_DELVAL) ? 80 : 60))
				val = value_pool[$urandom_range(15)];
			else
				val = $urandom;
			queue_cmd(act, val, (n % 250 == 125), (n >= RAND_WORDS - CALM_WORDS));
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (words_in != words_total)
			@(posedge clk);
		while (view_fifo.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/slq_pkg.sv
rtl/slq_if.sv
rtl/slq_cell.sv
rtl/sorted_list_queue.sv
dv/tb_sorted_list_queue.sv
